// ----- hw/rtl/dstt_pkg.sv -----
// Package for the slot-table topological sorter: sizes, command and status codes,
// the state encoding and the edge memory request type.
// No dependencies.
package dstt_pkg;

  localparam int MAX_NODES       = 16;
  localparam int EDGE_COUNT_BITS = 4;
  localparam int NODE_W          = $clog2(MAX_NODES);
  localparam int CNT_W           = NODE_W + 1;
  localparam int EDGE_AW         = 2 * NODE_W;
  localparam int EDGE_DEPTH      = MAX_NODES * MAX_NODES;
  localparam int INDEG_W         = EDGE_COUNT_BITS + NODE_W;
  localparam int SEQ_W           = EDGE_AW + 1;

  localparam logic [EDGE_COUNT_BITS-1:0] EDGE_MAX = '1;

  localparam logic [1:0] CMD_ADD_NODE = 2'd0;
  localparam logic [1:0] CMD_REMOVE   = 2'd1;
  localparam logic [1:0] CMD_ADD_EDGE = 2'd2;
  localparam logic [1:0] CMD_READ     = 2'd3;

  localparam logic [2:0] STS_OK    = 3'd0;
  localparam logic [2:0] STS_FULL  = 3'd1;
  localparam logic [2:0] STS_BADID = 3'd2;
  localparam logic [2:0] STS_CYCLE = 3'd3;
  localparam logic [2:0] STS_SAT   = 3'd4;

  typedef enum logic [8:0] {
    ST_INIT  = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_CLR   = 9'b000000100,
    ST_DEG   = 9'b000001000,
    ST_SEED  = 9'b000010000,
    ST_RELAX = 9'b000100000,
    ST_DONE  = 9'b001000000,
    ST_EDGE  = 9'b010000000,
    ST_EMIT  = 9'b100000000
  } state_t;

  typedef struct packed {
    logic                       we;
    logic [EDGE_AW-1:0]         addr;
    logic [EDGE_COUNT_BITS-1:0] wdata;
  } edge_req_t;

endpackage

// ----- hw/rtl/dstt_edge_ram.sv -----
// Single-port edge count memory, one entry per parent/child pair.
// Depends on dstt_pkg for sizes and the request struct.
module dstt_edge_ram
  import dstt_pkg::*;
(
  input  logic                       clk,
  input  edge_req_t                  req,
  output logic [EDGE_COUNT_BITS-1:0] rdata
);

  logic [EDGE_COUNT_BITS-1:0] mem [EDGE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end else begin
      rdata <= mem[req.addr];
    end
  end

endmodule

// ----- hw/rtl/dag_slot_table_topo_sort.sv -----
// Top level of the slot-table graph with Kahn topological sort.
// Depends on dstt_pkg and dstt_edge_ram.
//
// Commands are taken when start is high and busy is low; results appear for one
// cycle each on out_valid and cannot be held off. After reset the block clears its
// edge memory with busy high. Add node answers in the cycle after acceptance, add
// edge answers from ST_EDGE, where the count read in idle is updated, and read order
// emits one slot a cycle. Remove clears the slot's edges, gathers in-degrees, seeds
// the queue, relaxes the row of each dequeued node and checks that every live slot
// was sorted before its run of results; the single port of the edge memory, one
// access a cycle, paces these steps.
module dag_slot_table_topo_sort
  import dstt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_command,
  input  logic [NODE_W-1:0] in_first_id,
  input  logic [NODE_W-1:0] in_second_id,
  output logic              out_valid,
  output logic [NODE_W-1:0] out_node_id,
  output logic              out_last,
  output logic [2:0]        out_status
);

  state_t                     state_r;
  logic [SEQ_W-1:0]           cnt_r;
  logic [MAX_NODES-1:0]       live_r;
  logic [CNT_W-1:0]           slots_used_r;
  logic [NODE_W-1:0]          free_head_r;
  logic [CNT_W-1:0]           free_count_r;
  logic [NODE_W-1:0]          fifo_r [MAX_NODES];
  logic [NODE_W-1:0]          order_r [MAX_NODES];
  logic [CNT_W-1:0]           order_len_r;
  logic [NODE_W-1:0]          queue_r [MAX_NODES];
  logic [CNT_W-1:0]           qh_r;
  logic [CNT_W-1:0]           qt_r;
  logic [INDEG_W-1:0]         indeg_r [MAX_NODES];
  logic [NODE_W-1:0]          sel_a_r;
  logic [NODE_W-1:0]          sel_b_r;
  logic                       pend_r;
  logic [EDGE_AW-1:0]         pa_r;
  logic                       out_valid_r;
  logic [NODE_W-1:0]          out_node_id_r;
  logic                       out_last_r;
  logic [2:0]                 out_status_r;

  edge_req_t                  req;
  logic [EDGE_COUNT_BITS-1:0] erd;
  logic                       accept;
  logic                       issue;
  logic [NODE_W-1:0]          cur_p;
  logic [NODE_W-1:0]          pd_p;
  logic [NODE_W-1:0]          pd_c;
  logic [INDEG_W-1:0]         n_ext;
  logic [INDEG_W-1:0]         relax_val;
  logic                       relax_hit;
  logic                       relax_push;
  logic                       seed_push;
  logic [CNT_W-1:0]           qt_after;
  logic                       a_ok;
  logic                       b_ok;

  dstt_edge_ram u_edge_ram (
    .clk   (clk),
    .req   (req),
    .rdata (erd)
  );

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);
  assign cur_p  = queue_r[qh_r[NODE_W-1:0]];
  assign pd_p   = pa_r[EDGE_AW-1:NODE_W];
  assign pd_c   = pa_r[NODE_W-1:0];
  assign n_ext  = INDEG_W'(erd);
  assign a_ok   = (CNT_W'(in_first_id) < CNT_W'(MAX_NODES)) && live_r[in_first_id];
  assign b_ok   = (CNT_W'(in_second_id) < CNT_W'(MAX_NODES)) && live_r[in_second_id];

  // Edge memory requests: clearing sweeps, the add edge read in idle, the two scans and the edge update.
  always_comb begin
    req       = '0;
    issue     = 1'b0;
    case (state_r)
      ST_INIT: begin
        req.we   = 1'b1;
        req.addr = cnt_r[EDGE_AW-1:0];
      end
      ST_CLR: begin
        req.we   = 1'b1;
        req.addr = (cnt_r[NODE_W] == 1'b0) ? {sel_a_r, cnt_r[NODE_W-1:0]}
                                           : {cnt_r[NODE_W-1:0], sel_a_r};
      end
      ST_IDLE: begin
        req.addr = {in_first_id, in_second_id};
      end
      ST_DEG: begin
        issue    = (cnt_r < SEQ_W'(EDGE_DEPTH));
        // Parent is the inner index so each in-degree is summed in one run.
        req.addr = {cnt_r[NODE_W-1:0], cnt_r[EDGE_AW-1:NODE_W]};
      end
      ST_RELAX: begin
        issue    = (cnt_r < SEQ_W'(MAX_NODES));
        req.addr = {cur_p, cnt_r[NODE_W-1:0]};
      end
      ST_EDGE: begin
        req.we    = (erd != EDGE_MAX);
        req.addr  = {sel_a_r, sel_b_r};
        req.wdata = erd + EDGE_COUNT_BITS'(1);
      end
      default: begin
        req = '0;
      end
    endcase
  end

  always_comb begin
    relax_hit  = pend_r && (erd != '0) && live_r[pd_c] && (indeg_r[pd_c] != '0);
    relax_val  = (indeg_r[pd_c] > n_ext) ? indeg_r[pd_c] - n_ext : '0;
    relax_push = relax_hit && (relax_val == '0) && (qt_r < CNT_W'(MAX_NODES));
    seed_push  = live_r[cnt_r[NODE_W-1:0]] && (indeg_r[cnt_r[NODE_W-1:0]] == '0);
    qt_after   = qt_r;
    if ((state_r == ST_RELAX && relax_push) || (state_r == ST_SEED && seed_push)) begin
      qt_after = qt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      cnt_r        <= '0;
      live_r       <= '0;
      slots_used_r <= '0;
      free_head_r  <= '0;
      free_count_r <= '0;
      order_len_r  <= '0;
      qh_r         <= '0;
      qt_r         <= '0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      pend_r      <= issue;
      if (issue) begin
        pa_r <= req.addr;
      end
      case (state_r)
        ST_INIT: begin
          cnt_r <= cnt_r + SEQ_W'(1);
          if (cnt_r == SEQ_W'(EDGE_DEPTH - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            sel_a_r       <= in_first_id;
            sel_b_r       <= in_second_id;
            out_node_id_r <= '0;
            out_last_r    <= 1'b1;
            case (in_command)
              CMD_ADD_NODE: begin
                out_valid_r <= 1'b1;
                if (free_count_r != '0) begin
                  out_node_id_r              <= fifo_r[free_head_r];
                  out_status_r               <= STS_OK;
                  live_r[fifo_r[free_head_r]] <= 1'b1;
                  free_head_r  <= (free_head_r == NODE_W'(MAX_NODES - 1)) ? '0
                                  : free_head_r + NODE_W'(1);
                  free_count_r <= free_count_r - CNT_W'(1);
                end else if (slots_used_r < CNT_W'(MAX_NODES)) begin
                  out_node_id_r                     <= slots_used_r[NODE_W-1:0];
                  out_status_r                      <= STS_OK;
                  live_r[slots_used_r[NODE_W-1:0]]  <= 1'b1;
                  slots_used_r                      <= slots_used_r + CNT_W'(1);
                end else begin
                  out_status_r <= STS_FULL;
                end
              end
              CMD_REMOVE: begin
                if (!a_ok) begin
                  out_valid_r  <= 1'b1;
                  out_status_r <= STS_BADID;
                end else begin
                  live_r[in_first_id] <= 1'b0;
                  fifo_r[free_head_r + free_count_r[NODE_W-1:0]] <= in_first_id;
                  if (free_count_r < CNT_W'(MAX_NODES)) begin
                    free_count_r <= free_count_r + CNT_W'(1);
                  end
                  cnt_r   <= '0;
                  state_r <= ST_CLR;
                end
              end
              CMD_ADD_EDGE: begin
                if (!a_ok || !b_ok) begin
                  out_valid_r  <= 1'b1;
                  out_status_r <= STS_BADID;
                end else begin
                  state_r <= ST_EDGE;
                end
              end
              default: begin
                if (order_len_r != '0) begin
                  cnt_r   <= '0;
                  state_r <= ST_EMIT;
                end
              end
            endcase
          end
        end
        ST_EDGE: begin
          out_valid_r   <= 1'b1;
          out_node_id_r <= '0;
          out_last_r    <= 1'b1;
          out_status_r  <= (erd == EDGE_MAX) ? STS_SAT : STS_OK;
          state_r       <= ST_IDLE;
        end
        ST_CLR: begin
          cnt_r <= cnt_r + SEQ_W'(1);
          if (cnt_r == SEQ_W'(2 * MAX_NODES - 1)) begin
            cnt_r   <= '0;
            qh_r    <= '0;
            qt_r    <= '0;
            for (int i = 0; i < MAX_NODES; i++) begin
              indeg_r[i] <= '0;
            end
            state_r <= ST_DEG;
          end
        end
        ST_DEG: begin
          if (issue) begin
            cnt_r <= cnt_r + SEQ_W'(1);
          end
          if (pend_r && live_r[pd_p] && live_r[pd_c]) begin
            indeg_r[pd_c] <= indeg_r[pd_c] + n_ext;
          end
          if (!issue) begin
            cnt_r   <= '0;
            state_r <= ST_SEED;
          end
        end
        ST_SEED: begin
          cnt_r <= cnt_r + SEQ_W'(1);
          if (seed_push) begin
            queue_r[qt_r[NODE_W-1:0]] <= cnt_r[NODE_W-1:0];
          end
          qt_r <= qt_after;
          if (cnt_r == SEQ_W'(MAX_NODES - 1)) begin
            cnt_r   <= '0;
            state_r <= (qt_after != '0) ? ST_RELAX : ST_DONE;
          end
        end
        ST_RELAX: begin
          cnt_r <= cnt_r + SEQ_W'(1);
          if (relax_hit) begin
            indeg_r[pd_c] <= relax_val;
          end
          if (relax_push) begin
            queue_r[qt_r[NODE_W-1:0]] <= pd_c;
          end
          qt_r <= qt_after;
          // The last child of this row is settled here; move to the next queued node.
          if (!issue) begin
            cnt_r   <= '0;
            qh_r    <= qh_r + CNT_W'(1);
            state_r <= ((qh_r + CNT_W'(1)) < qt_after) ? ST_RELAX : ST_DONE;
          end
        end
        ST_DONE: begin
          state_r <= ST_IDLE;
          if (CNT_W'($countones(live_r)) == qt_r) begin
            for (int i = 0; i < MAX_NODES; i++) begin
              order_r[i] <= queue_r[i];
            end
            order_len_r <= qt_r;
            if (qt_r != '0) begin
              cnt_r   <= '0;
              state_r <= ST_EMIT;
            end
          end else begin
            out_valid_r   <= 1'b1;
            out_node_id_r <= '0;
            out_last_r    <= 1'b1;
            out_status_r  <= STS_CYCLE;
          end
        end
        ST_EMIT: begin
          out_valid_r   <= 1'b1;
          out_node_id_r <= order_r[cnt_r[NODE_W-1:0]];
          out_status_r  <= STS_OK;
          out_last_r    <= (CNT_W'(cnt_r) + CNT_W'(1) == order_len_r);
          cnt_r         <= cnt_r + SEQ_W'(1);
          if (CNT_W'(cnt_r) + CNT_W'(1) == order_len_r) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_node_id = out_node_id_r;
  assign out_last    = out_last_r;
  assign out_status  = out_status_r;

  // A run of order results has no gaps.
  a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("order run broken");

  // Only ok results come in runs.
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STS_OK) |-> out_last)
    else $error("error result not last");

  // The sort queue head never passes its tail.
  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    qh_r <= qt_r)
    else $error("queue head past tail");

  // Nothing is emitted while the edge memory is cleared after reset.
  a_init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INIT) |-> !out_valid && busy)
    else $error("output during clearing pass");

endmodule
